// ----- rtl/exptok_pkg.sv -----
// Package for the expression tokenizer: token limits, kind codes, scan modes,
// character constants, result and state records, character class functions.
// No dependencies.
`timescale 1ns / 1ps

package exptok_pkg;

  localparam int MAX_TOKENS = 256;
  localparam int CNT_W      = $clog2(MAX_TOKENS + 1);

  localparam logic [2:0] KIND_OP    = 3'd0;
  localparam logic [2:0] KIND_SHIFT = 3'd1;
  localparam logic [2:0] KIND_INT   = 3'd2;
  localparam logic [2:0] KIND_WORD  = 3'd3;
  localparam logic [2:0] KIND_ID    = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LESS  = 8'h3C;
  localparam logic [7:0] CH_GREAT = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_Q     = 8'h51;

  typedef enum logic [2:0] {
    MODE_NONE  = 3'd0,
    MODE_SHIFT = 3'd1,
    MODE_INT_S = 3'd2,
    MODE_INT_C = 3'd3,
    MODE_ID_S  = 3'd4,
    MODE_ID_C  = 3'd5,
    MODE_WORD  = 3'd6
  } mode_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [2:0] token_kind;
    logic       token_start;
    logic       token_end;
    logic [7:0] token_index;
    logic       error;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0]       pend_char;
    logic             pend_valid;
    mode_t            mode;
    logic [CNT_W-1:0] count;
    logic             err;
  } tok_state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_single_op(input logic [7:0] c);
    return c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3A, 8'h5B,
                     8'h5D, 8'h7B, 8'h7D, 8'h28, 8'h29, 8'h3F, 8'h3D};
  endfunction

  // Low byte of the token count, or of the count less one.
  function automatic logic [7:0] idx_of(input logic [CNT_W-1:0] count,
                                        input logic minus_one);
    logic [CNT_W+7:0] ext;
    ext = {8'b0, count} - {{(CNT_W+7){1'b0}}, minus_one};
    return ext[7:0];
  endfunction

endpackage

// ----- rtl/exptok_if.sv -----
// Channel interfaces of the expression tokenizer: the character input and
// the token result output. No dependencies.
`timescale 1ns / 1ps

interface exptok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface exptok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [2:0] token_kind;
  logic       token_start;
  logic       token_end;
  logic [7:0] token_index;
  logic       error;
  logic       last;

  modport source (output valid, output char_out, output token_kind,
                  output token_start, output token_end, output token_index,
                  output error, output last, input ready);
  modport sink (input valid, input char_out, input token_kind,
                input token_start, input token_end, input token_index,
                input error, input last, output ready);
endinterface

// ----- rtl/expression_tokenizer.sv -----
// Top level of the expression tokenizer: scan state registers, step logic
// and result queue. Depends on exptok_pkg, exptok_if, exptok_step, exptok_outq.
//
//   channel   direction  carries
//   text      in         char_in, end_of_text
//   tokens    out        char_out, token_kind, token_start, token_end,
//                        token_index, error, last
//
// One character is taken per cycle; each gives zero, one or two results.
// A character enters while at least two queue entries are free, so a stream
// of characters that give one result or fewer runs at one per cycle, and the
// output port at one result per cycle sets the rate for two-result items.
// Results pass through the queue registers on their way out. Reset empties the
// queue and clears the scan state; output stalls only fill the queue.
`timescale 1ns / 1ps

module expression_tokenizer
  import exptok_pkg::*;
(
  input  logic clk,
  input  logic rst,
  exptok_in_if.sink    text,
  exptok_out_if.source tokens
);

  tok_state_t state;
  tok_state_t state_next;
  res_t       res0;
  res_t       res1;
  logic [1:0] res_count;
  logic       room;
  logic       accept;

  assign text.ready = room;
  assign accept     = text.valid && room;

  exptok_step u_step (
    .state       (state),
    .char_in     (text.char_in),
    .end_of_text (text.end_of_text),
    .state_next  (state_next),
    .res0        (res0),
    .res1        (res1),
    .res_count   (res_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  exptok_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (accept ? res_count : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .room       (room),
    .tokens     (tokens)
  );

endmodule

// ----- rtl/exptok_step.sv -----
// Next-state and result logic for one character: resolves the lookahead
// character, starts tokens, raises errors and closes the text.
// Depends on exptok_pkg.
`timescale 1ns / 1ps

module exptok_step
  import exptok_pkg::*;
(
  input  tok_state_t state,
  input  logic [7:0] char_in,
  input  logic       end_of_text,
  output tok_state_t state_next,
  output res_t       res0,
  output res_t       res1,
  output logic [1:0] res_count
);

  function automatic res_t mk(input logic [7:0] ch, input logic [2:0] kind,
                              input logic s, input logic e,
                              input logic [7:0] idx, input logic err);
    res_t r;
    r.char_out    = ch;
    r.token_kind  = kind;
    r.token_start = s;
    r.token_end   = e;
    r.token_index = idx;
    r.error       = err;
    r.last        = 1'b0;
    return r;
  endfunction

  res_t       res [2];
  logic [1:0] n;
  logic       absorbed;
  logic       ends;
  logic       starts;
  logic       s_flag;
  logic [7:0] p;
  logic [7:0] idx_p;
  logic [2:0] end_kind;
  tok_state_t st;

  always_comb begin
    res[0]   = '0;
    res[1]   = '0;
    n        = 2'd0;
    absorbed = 1'b0;
    st       = state;
    p        = state.pend_char;
    idx_p    = idx_of(state.count, 1'b1);
    ends     = end_of_text || (char_in == CH_NUL);
    starts   = is_single_op(char_in) || (char_in == CH_LESS) || (char_in == CH_GREAT) ||
               is_word(char_in);
    s_flag   = 1'b0;
    end_kind = KIND_OP;

    if (!state.err && (char_in != CH_NUL)) begin
      if (state.pend_valid) begin
        case (state.mode)
          MODE_SHIFT: begin
            if (char_in == p) begin
              res[n[0]] = mk(p, KIND_SHIFT, 1'b1, 1'b0, idx_p, 1'b0);
              n = n + 2'd1;
              res[n[0]] = mk(char_in, KIND_SHIFT, 1'b0, 1'b1, idx_p, 1'b0);
              n = n + 2'd1;
              absorbed = 1'b1;
              st.pend_valid = 1'b0;
              st.pend_char  = CH_NUL;
              st.mode       = MODE_NONE;
            end else begin
              res[n[0]] = mk(p, KIND_OP, 1'b1, 1'b1, idx_p, 1'b0);
              n = n + 2'd1;
            end
          end
          MODE_WORD: begin
            if (((p == CH_L) && (char_in == CH_T)) || ((p == CH_G) && (char_in == CH_T)) ||
                ((p == CH_E) && (char_in == CH_Q))) begin
              res[n[0]] = mk(p, KIND_WORD, 1'b1, 1'b0, idx_p, 1'b0);
              n = n + 2'd1;
              res[n[0]] = mk(char_in, KIND_WORD, 1'b0, 1'b1, idx_p, 1'b0);
              n = n + 2'd1;
              absorbed = 1'b1;
              st.pend_valid = 1'b0;
              st.pend_char  = CH_NUL;
              st.mode       = MODE_NONE;
            end else if (is_word(char_in)) begin
              res[n[0]] = mk(p, KIND_ID, 1'b1, 1'b0, idx_p, 1'b0);
              n = n + 2'd1;
              absorbed = 1'b1;
              st.pend_char = char_in;
              st.mode      = MODE_ID_C;
            end else begin
              res[n[0]] = mk(p, KIND_ID, 1'b1, 1'b1, idx_p, 1'b0);
              n = n + 2'd1;
            end
          end
          MODE_INT_S, MODE_INT_C: begin
            s_flag = (state.mode == MODE_INT_S);
            if (is_digit(char_in)) begin
              res[n[0]] = mk(p, KIND_INT, s_flag, 1'b0, idx_p, 1'b0);
              n = n + 2'd1;
              absorbed = 1'b1;
              st.pend_char = char_in;
              st.mode      = MODE_INT_C;
            end else begin
              res[n[0]] = mk(p, KIND_INT, s_flag, 1'b1, idx_p, 1'b0);
              n = n + 2'd1;
            end
          end
          MODE_ID_S, MODE_ID_C: begin
            s_flag = (state.mode == MODE_ID_S);
            if (is_word(char_in)) begin
              res[n[0]] = mk(p, KIND_ID, s_flag, 1'b0, idx_p, 1'b0);
              n = n + 2'd1;
              absorbed = 1'b1;
              st.pend_char = char_in;
              st.mode      = MODE_ID_C;
            end else begin
              res[n[0]] = mk(p, KIND_ID, s_flag, 1'b1, idx_p, 1'b0);
              n = n + 2'd1;
            end
          end
          default: begin
          end
        endcase
        if (!absorbed) begin
          st.pend_valid = 1'b0;
          st.pend_char  = CH_NUL;
          st.mode       = MODE_NONE;
        end
      end

      if (!absorbed && (char_in != CH_SPACE)) begin
        if (!starts || (state.count >= CNT_W'(MAX_TOKENS))) begin
          res[n[0]] = mk(char_in, KIND_OP, 1'b0, 1'b0, idx_of(state.count, 1'b0), 1'b1);
          n = n + 2'd1;
          st.err        = 1'b1;
          st.pend_valid = 1'b0;
          st.pend_char  = CH_NUL;
          st.mode       = MODE_NONE;
        end else begin
          st.count = CNT_W'(state.count + 1'b1);
          if (is_single_op(char_in)) begin
            res[n[0]] = mk(char_in, KIND_OP, 1'b1, 1'b1, idx_of(state.count, 1'b0), 1'b0);
            n = n + 2'd1;
          end else begin
            st.pend_valid = 1'b1;
            st.pend_char  = char_in;
            if ((char_in == CH_LESS) || (char_in == CH_GREAT)) begin
              st.mode = MODE_SHIFT;
            end else if (is_digit(char_in)) begin
              st.mode = MODE_INT_S;
            end else if ((char_in == CH_L) || (char_in == CH_G) || (char_in == CH_E)) begin
              st.mode = MODE_WORD;
            end else begin
              st.mode = MODE_ID_S;
            end
          end
        end
      end
    end

    if (ends) begin
      if (!st.err && st.pend_valid) begin
        s_flag = 1'b1;
        case (st.mode)
          MODE_INT_S: end_kind = KIND_INT;
          MODE_INT_C: begin
            end_kind = KIND_INT;
            s_flag   = 1'b0;
          end
          MODE_ID_S, MODE_WORD: end_kind = KIND_ID;
          MODE_ID_C: begin
            end_kind = KIND_ID;
            s_flag   = 1'b0;
          end
          default: end_kind = KIND_OP;
        endcase
        res[n[0]] = mk(st.pend_char, end_kind, s_flag, 1'b1, idx_of(st.count, 1'b1), 1'b0);
        n = n + 2'd1;
      end
      if (n == 2'd0) begin
        res[0] = mk(CH_NUL, KIND_OP, 1'b0, 1'b0, 8'd0, st.err);
        res[0].last = 1'b1;
        n = 2'd1;
      end else if (n == 2'd1) begin
        res[0].last = 1'b1;
      end else begin
        res[1].last = 1'b1;
      end
      st = '0;
    end

    state_next = st;
    res0       = res[0];
    res1       = res[1];
    res_count  = n;
  end

endmodule

// ----- rtl/exptok_outq.sv -----
// Four-entry result queue: takes up to two results in a cycle and hands
// one a cycle to a ready output channel. Depends on exptok_pkg, exptok_if.
`timescale 1ns / 1ps

module exptok_outq
  import exptok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  res_t       push0,
  input  res_t       push1,
  output logic       room,
  exptok_out_if.source tokens
);

  res_t       slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       pop;
  res_t       head;

  assign pop  = tokens.valid && tokens.ready;
  assign room = (fill <= 3'd2);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      fill   <= fill + {1'b0, push_count} - {2'b0, pop};
    end
  end

  assign tokens.valid       = (fill != 3'd0);
  assign tokens.char_out    = head.char_out;
  assign tokens.token_kind  = head.token_kind;
  assign tokens.token_start = head.token_start;
  assign tokens.token_end   = head.token_end;
  assign tokens.token_index = head.token_index;
  assign tokens.error       = head.error;
  assign tokens.last        = head.last;

endmodule
